>>> rtl/bsf_pkg.sv
// shared types and constants of the byte stuffing framer
package bsf_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [BYTE_W-1:0] RESET_FLAG   = 8'h7E;
	localparam logic [BYTE_W-1:0] RESET_ESCAPE = 8'b0111_1101;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLAG   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 1'b1;

	// emission steps of one item, in output order
	localparam int unsigned STEP_CLOSE = 0;
	localparam int unsigned STEP_OPEN  = 1;
	localparam int unsigned STEP_TESC  = 2;
	localparam int unsigned STEP_TYPE  = 3;
	localparam int unsigned STEP_DESC  = 4;
	localparam int unsigned STEP_DATA  = 5;
	localparam int unsigned NUM_STEPS  = 6;

	typedef logic [NUM_STEPS-1:0] step_mask_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] msg_type;
		step_mask_t        steps;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] flag_byte;
		logic [BYTE_W-1:0] escape_byte;
	} cfg_t;

endpackage

>>> rtl/bsf_front.sv
// front end: takes items, tracks the open frame and plans the bytes of each item
module bsf_front import bsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [BYTE_W-1:0] msg_type,
	input  cfg_t              cfg,
	output item_t             item
);

	logic              frame_open_q;
	logic [BYTE_W-1:0] open_type_q;
	logic              close_frame;
	logic              open_frame;
	logic              type_special;
	logic              data_special;

	always_comb begin
		close_frame  = frame_open_q && (open_type_q != msg_type);
		open_frame   = !frame_open_q || close_frame;
		type_special = (msg_type == cfg.flag_byte) || (msg_type == cfg.escape_byte);
		data_special = (data_byte == cfg.flag_byte) || (data_byte == cfg.escape_byte);

		item.data_byte              = data_byte;
		item.msg_type               = msg_type;
		item.steps                  = '0;
		item.steps[STEP_CLOSE]      = close_frame;
		item.steps[STEP_OPEN]       = open_frame;
		item.steps[STEP_TESC]       = open_frame && type_special;
		item.steps[STEP_TYPE]       = open_frame;
		item.steps[STEP_DESC]       = data_special;
		item.steps[STEP_DATA]       = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			open_type_q  <= '0;
		end else if (accept) begin
			frame_open_q <= 1'b1;
			open_type_q  <= msg_type;
		end
	end

endmodule

>>> rtl/bsf_queue.sv
// short queue of planned items between front and back end
module bsf_queue import bsf_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/bsf_back.sv
// back end: walks the planned steps of the head item, one output byte a cycle unless stalled
module bsf_back import bsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             head,
	input  logic              empty,
	input  cfg_t              cfg,
	output logic              pop,
	input  logic              result_stall,
	output logic              result_valid,
	output logic [BYTE_W-1:0] out_byte,
	output logic              run_last
);

	step_mask_t        done_q;
	step_mask_t        pending;
	step_mask_t        low;
	logic              last;
	logic              advance;
	logic [BYTE_W-1:0] next_byte;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              run_last_q;

	always_comb begin
		pending = head.steps & ~done_q;
		// lowest step still to send
		low     = pending & (~pending + 1'b1);
		last    = ((pending & ~low) == '0);
		advance = !empty && (!out_valid_q || !result_stall);
		pop     = advance && last;

		if (low[STEP_CLOSE] || low[STEP_OPEN]) begin
			next_byte = cfg.flag_byte;
		end else if (low[STEP_TESC] || low[STEP_DESC]) begin
			next_byte = cfg.escape_byte;
		end else if (low[STEP_TYPE]) begin
			next_byte = head.msg_type;
		end else begin
			next_byte = head.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				done_q      <= last ? '0 : (done_q | low);
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= next_byte;
			run_last_q <= last;
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign run_last     = run_last_q;

endmodule

>>> rtl/byte_stuffing_framer.sv
// Byte stuffing framer top level
//
// Items arrive on the item channel (item_valid/item_stall) with data_byte and
// msg_type. Framed bytes leave on the result channel (result_valid/
// result_stall) as out_byte, one per cycle unless stalled, with run_last set
// on the final byte of each item, which is always its payload byte.
// A frame starts with the flag byte and the type byte; a change of msg_type
// closes the open frame with a flag first. The type byte and any payload byte
// equal to the flag or escape value are preceded by the escape byte.
// The first byte of an item passes through the queue and then the output
// register on its way to the result port. Each item produces 1 to 6 bytes;
// output runs at one byte per cycle while result_stall is low and items wait.
// An item that stays in the open frame with a plain byte sends only that byte.
// The front end takes a new item while earlier ones are still being sent, until
// the two-entry queue between front and back end is full.
// Reset clears the frame state, empties the queue and drops result_valid; the
// flag and escape registers return to 0x7E and 0x7D.
// While result_stall is high a valid byte holds and the back end waits;
// the front end keeps taking items until the queue fills, then raises
// item_stall.
module byte_stuffing_framer import bsf_pkg::*; #(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic [BYTE_W-1:0]    msg_type,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 run_last
);

	cfg_t  cfg_q;
	item_t planned;
	item_t head;
	logic  accept;
	logic  pop;
	logic  empty;
	logic  full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte   <= RESET_FLAG;
			cfg_q.escape_byte <= RESET_ESCAPE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLAG:   cfg_q.flag_byte   <= cfg_data;
				REG_ESCAPE: cfg_q.escape_byte <= cfg_data;
				default:    cfg_q             <= cfg_q;
			endcase
		end
	end

	assign item_stall = full;
	assign accept     = item_valid && !full;

	bsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.msg_type  (msg_type),
		.cfg       (cfg_q),
		.item      (planned)
	);

	bsf_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (planned),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	bsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.cfg          (cfg_q),
		.pop          (pop),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.out_byte     (out_byte),
		.run_last     (run_last)
	);

endmodule

>>> rtl/bsf_checker.sv
// port-level checks of the byte stuffing framer, bound to the top level
module bsf_checker import bsf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [BYTE_W-1:0]    out_byte,
	input logic                 run_last
);

	// a stalled result byte holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(out_byte) && $stable(run_last))
		else $error("stalled result changed");

	// bytes of one item follow without a gap
	a_item_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !run_last |=> result_valid)
		else $error("gap inside the bytes of one item");

	// nothing is shown right out of reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid && !item_stall)
		else $error("result or stall right after reset");

endmodule

bind byte_stuffing_framer bsf_checker u_bsf_checker (.*);

>>> verif/tb_top.sv
// testbench for the byte stuffing framer: directed table, random frames, scoreboard
`timescale 1ns / 100ps

module tb_top;
	import bsf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		byte_t out_byte;
		logic  run_last;
	} framed_t;

	// one directed item; n != 0 means the byte sequence is typed in, first byte at the top
	typedef struct packed {
		logic        wr;
		byte_t       new_flag;
		byte_t       new_esc;
		byte_t       d;
		byte_t       t;
		logic [2:0]  n;
		logic [47:0] seq;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	byte_t                cfg_data;
	logic                 item_valid;
	logic                 item_stall;
	byte_t                data_byte;
	byte_t                msg_type;
	logic                 result_valid;
	logic                 result_stall;
	byte_t                out_byte;
	logic                 run_last;

	byte_stuffing_framer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.data_byte    (data_byte),
		.msg_type     (msg_type),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.run_last     (run_last)
	);

	// framer state as seen by the scoreboard
	byte_t flag_q = RESET_FLAG;
	byte_t esc_q = RESET_ESCAPE;
	logic  fr_open = 1'b0;
	byte_t fr_type = '0;
	logic  fr_type_sent = 1'b0;

	byte_t   staged_bytes[$];
	framed_t framed_q[$];

	logic [2:0]  cur_n = '0;
	logic [47:0] cur_seq = '0;

	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned stall_pct = 0;
	int unsigned burst_left = 0;
	bit          no_idle = 1'b0;
	bit          hold_off_req = 1'b0;

	row_t plan [0:21] = '{
		{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd3, 48'h7E_00_00_00_00_00},
		{1'b0, 8'h00, 8'h00, 8'h7E, 8'h00, 3'd2, 48'h7D_7E_00_00_00_00},
		{1'b0, 8'h00, 8'h00, 8'h7D, 8'h00, 3'd2, 48'h7D_7D_00_00_00_00},
		{1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 3'd1, 48'hFF_00_00_00_00_00},
		{1'b0, 8'h00, 8'h00, 8'h00, 8'h7E, 3'd5, 48'h7E_7E_7D_7E_00_00},
		{1'b0, 8'h00, 8'h00, 8'h7E, 8'h7D, 3'd6, 48'h7E_7E_7D_7D_7D_7E},
		{1'b0, 8'h00, 8'h00, 8'h01, 8'hFF, 3'd4, 48'h7E_7E_FF_01_00_00},
		{1'b0, 8'h00, 8'h00, 8'h80, 8'hFF, 3'd1, 48'h80_00_00_00_00_00},
		{1'b0, 8'h00, 8'h00, 8'h55, 8'h00, 3'd4, 48'h7E_7E_00_55_00_00},
		// flag equal to escape: escaped once
		{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 48'h00_00_00_00_00_00},
		{1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF, 3'd4, 48'h00_00_FF_FF_00_00},
		{1'b0, 8'h00, 8'h00, 8'h00, 8'h01, 3'd0, 48'h0},
		{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 48'h0},
		{1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 3'd0, 48'h0},
		{1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00, 3'd0, 48'h0},
		{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 48'h0},
		{1'b0, 8'h00, 8'h00, 8'hAA, 8'h55, 3'd0, 48'h0},
		{1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF, 3'd0, 48'h0},
		{1'b0, 8'h00, 8'h00, 8'hFF, 8'h00, 3'd0, 48'h0},
		{1'b0, 8'h00, 8'h00, 8'h5A, 8'hA5, 3'd0, 48'h0},
		{1'b1, 8'h7E, 8'h7D, 8'h7E, 8'h7E, 3'd0, 48'h0},
		{1'b0, 8'h00, 8'h00, 8'h3C, 8'h7D, 3'd0, 48'h0}
	};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void stage_stuffed(input byte_t b);
		if (b == flag_q || b == esc_q)
			staged_bytes.push_back(esc_q);
		staged_bytes.push_back(b);
	endfunction

	// bytes that one item adds to the framed stream
	function automatic void frame_item(input byte_t d, input byte_t t);
		staged_bytes.delete();
		if (fr_open && fr_type != t) begin
			staged_bytes.push_back(flag_q);
			fr_open = 1'b0;
		end
		if (fr_type != t) begin
			fr_type = t;
			fr_type_sent = 1'b0;
		end
		if (!fr_open) begin
			staged_bytes.push_back(flag_q);
			fr_open = 1'b1;
		end
		if (!fr_type_sent) begin
			stage_stuffed(fr_type);
			fr_type_sent = 1'b1;
		end
		stage_stuffed(d);
	endfunction

	task automatic note_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : scoreboard_p
		int      k;
		framed_t got;
		framed_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_FLAG)
					flag_q = cfg_data;
				else if (cfg_index == REG_ESCAPE)
					esc_q = cfg_data;
			end
			if (item_valid && !item_stall) begin
				frame_item(data_byte, msg_type);
				// typed-in rows replace the predicted bytes
				if (cur_n != 0) begin
					staged_bytes.delete();
					for (k = 0; k < cur_n; k++)
						staged_bytes.push_back(cur_seq[47 - 8 * k -: 8]);
				end
				for (k = 0; k < staged_bytes.size(); k++)
					framed_q.push_back({staged_bytes[k], k == staged_bytes.size() - 1});
			end
			if (result_valid && !result_stall) begin
				got = {out_byte, run_last};
				if (framed_q.size() == 0) begin
					note_error($sformatf("byte %h last %b with nothing expected",
						out_byte, run_last));
				end else begin
					want = framed_q.pop_front();
					if (got !== want)
						note_error($sformatf("expected byte %h last %b, got byte %h last %b",
							want.out_byte, want.run_last, got.out_byte, got.run_last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[byte_stuffing_framer] ERROR");
			$finish;
		end
	end

	// receiver: stall runs of random length, plus one long hold-off on request
	initial begin : receiver_p
		int unsigned run_left;
		bit          stalled;
		run_left = 0;
		stalled = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (run_left == 0) begin
					stalled = $urandom_range(0, 99) < stall_pct;
					run_left = $urandom_range(1, 5);
				end
				run_left--;
				result_stall = stalled;
			end
		end
	end

	task automatic send_item(input byte_t d, input byte_t t, input logic [2:0] n,
			input logic [47:0] seq);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = no_idle ? 0 : $urandom_range(0, 5);
			repeat (gap) begin
				@(negedge clk);
				item_valid = 1'b0;
			end
		end
		@(negedge clk);
		item_valid = 1'b1;
		data_byte = d;
		msg_type = t;
		cur_n = n;
		cur_seq = seq;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		item_valid = 1'b0;
		burst_left = 0;
		while (framed_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_regs(input byte_t f, input byte_t e);
		wait_idle();
		cfg_we = 1'b1;
		cfg_index = REG_FLAG;
		cfg_data = f;
		@(negedge clk);
		cfg_index = REG_ESCAPE;
		cfg_data = e;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// frames of random length; flag and escape values show up often, extreme ones in the type
	task automatic send_frames(input int unsigned count);
		int unsigned frame_left;
		byte_t       t;
		byte_t       d;
		frame_left = 0;
		t = '0;
		for (int unsigned i = 0; i < count; i++) begin
			if (frame_left == 0) begin
				frame_left = $urandom_range(1, 10);
				case ($urandom_range(0, 9))
					0: t = flag_q;
					1: t = esc_q;
					2: t = 8'h00;
					3: t = 8'hFF;
					default: t = byte_t'($urandom_range(0, 255));
				endcase
			end
			case ($urandom_range(0, 7))
				0: d = flag_q;
				1: d = esc_q;
				default: d = byte_t'($urandom_range(0, 255));
			endcase
			send_item(d, t, 3'd0, 48'h0);
			frame_left--;
		end
	endtask

	initial begin : stimulus_p
		byte_t rnd;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FLAG;
		cfg_data = '0;
		item_valid = 1'b0;
		data_byte = '0;
		msg_type = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		stall_pct = 25;
		for (int i = 0; i < 22; i++) begin
			if (plan[i].wr)
				write_regs(plan[i].new_flag, plan[i].new_esc);
			send_item(plan[i].d, plan[i].t, plan[i].n, plan[i].seq);
		end

		// distinct random values, with a long hold-off while items keep coming
		rnd = byte_t'($urandom_range(0, 255));
		write_regs(rnd, rnd ^ byte_t'($urandom_range(1, 255)));
		stall_pct = 30;
		hold_off_req = 1'b1;
		send_frames(60);

		// flag equal to escape, no idling on either side
		rnd = byte_t'($urandom_range(0, 255));
		write_regs(rnd, rnd);
		stall_pct = 0;
		no_idle = 1'b1;
		send_frames(50);

		write_regs(8'h00, 8'hFF);
		stall_pct = 60;
		no_idle = 1'b0;
		send_frames(60);

		write_regs(RESET_FLAG, RESET_ESCAPE);
		stall_pct = 20;
		send_frames(60);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_cnt == 0)
			$display("[byte_stuffing_framer] OK");
		else
			$display("[byte_stuffing_framer] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/bsf_pkg.sv
rtl/bsf_front.sv
rtl/bsf_queue.sv
rtl/bsf_back.sv
rtl/byte_stuffing_framer.sv
rtl/bsf_checker.sv
verif/tb_top.sv
